FILE: rtl/bchd_pkg.sv
`default_nettype none
package bchd_pkg;

    localparam int HOLD_SLOTS = 4;
    localparam int DUR_W      = 24;
    localparam int TIMER_W    = 16;
    localparam int HCOUNT_W   = 3;
    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = REG_IDX_W + 2;
    localparam int APB_DATA_W = 32;

    typedef logic [DUR_W-1:0]   t_dur;
    typedef logic [TIMER_W-1:0] t_timer;

    localparam t_dur DUR_MAX = {DUR_W{1'b1}};

    // event codes carried in event_res
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_CLICK = 2'd1;
    localparam logic [1:0] EV_HOLD  = 2'd2;

    // pin levels (active low)
    localparam logic LVL_PRESSED  = 1'b0;
    localparam logic LVL_RELEASED = 1'b1;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_WAIT     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_COUNT    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_THRESH_0      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_THRESH_1      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_THRESH_2      = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_THRESH_3      = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_DEBOUNCE  = 3'd1,
        PH_PRESSED   = 3'd2,
        PH_WAIT_HOLD = 3'd3,
        PH_HOLD      = 3'd4
    } t_phase;

    typedef struct packed {
        logic pin_level;
        logic blocked;
    } t_in_item;

    typedef struct packed {
        logic [1:0] event_res;
        logic [1:0] hold_index;
    } t_out_item;

    typedef struct packed {
        logic       found;
        logic [1:0] index;
    } t_hold_pick;

endpackage
`default_nettype wire

FILE: rtl/button_click_hold_detector.sv
`default_nettype none
// Button click/hold detector, one item per millisecond tick.
// An accepted item's result is registered; it waits in the skid register if the output stalls.
// Throughput: one item per cycle while the skid register is empty; the whole tick update sits
// between the state and result registers, and a skid register keeps input open for one stalled result.
// Reset (i_rst_n low, synchronous): idle phase, timers and duration cleared, level released,
// registers to their defaults, result and skid registers empty.
module button_click_hold_detector import bchd_pkg::*; (
    input  var logic                  i_clk,
    input  var logic                  i_rst_n,
    // input channel
    input  var logic                  i_in_valid,
    output logic                      o_in_ready,
    input  var t_in_item              i_in_data,
    // result channel
    output logic                      o_out_valid,
    input  var logic                  i_out_ready,
    output t_out_item                 o_out_data,
    // configuration port
    input  var logic                  psel,
    input  var logic                  penable,
    input  var logic                  pwrite,
    input  var logic [APB_ADDR_W-1:0] paddr,
    input  var logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    t_timer                r_sample_period;
    t_timer                r_debounce;
    t_timer                r_hold_wait;
    logic [HCOUNT_W-1:0]   r_hold_count;
    t_dur [HOLD_SLOTS-1:0] r_thresh;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= TIMER_W'(20);
            r_debounce      <= TIMER_W'(50);
            r_hold_wait     <= TIMER_W'(1000);
            r_hold_count    <= '0;
            r_thresh        <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SAMPLE_PERIOD: r_sample_period <= pwdata[TIMER_W-1:0];
                REG_DEBOUNCE:      r_debounce      <= pwdata[TIMER_W-1:0];
                REG_HOLD_WAIT:     r_hold_wait     <= pwdata[TIMER_W-1:0];
                REG_HOLD_COUNT:    r_hold_count    <= pwdata[HCOUNT_W-1:0];
                REG_THRESH_0:      r_thresh[0]     <= pwdata[DUR_W-1:0];
                REG_THRESH_1:      r_thresh[1]     <= pwdata[DUR_W-1:0];
                REG_THRESH_2:      r_thresh[2]     <= pwdata[DUR_W-1:0];
                REG_THRESH_3:      r_thresh[3]     <= pwdata[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    // read back, zero-extended
    always_comb begin
        case (cfg_idx)
            REG_SAMPLE_PERIOD: prdata = APB_DATA_W'(r_sample_period);
            REG_DEBOUNCE:      prdata = APB_DATA_W'(r_debounce);
            REG_HOLD_WAIT:     prdata = APB_DATA_W'(r_hold_wait);
            REG_HOLD_COUNT:    prdata = APB_DATA_W'(r_hold_count);
            REG_THRESH_0:      prdata = APB_DATA_W'(r_thresh[0]);
            REG_THRESH_1:      prdata = APB_DATA_W'(r_thresh[1]);
            REG_THRESH_2:      prdata = APB_DATA_W'(r_thresh[2]);
            REG_THRESH_3:      prdata = APB_DATA_W'(r_thresh[3]);
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake: result register plus one skid entry
    // ---------------------------------------------------------------
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_data,  n_out_data;
    logic      r_skid_valid, n_skid_valid;
    t_out_item r_skid_data,  n_skid_data;
    logic      in_acc;
    t_out_item result;

    assign o_in_ready = !r_skid_valid;
    assign in_acc     = i_in_valid && o_in_ready;

    // ---------------------------------------------------------------
    // Tick state
    // ---------------------------------------------------------------
    t_phase r_phase,  n_phase;
    t_timer r_phase_cnt,  n_phase_cnt;
    t_timer r_sample_cnt, n_sample_cnt;
    logic   r_level,  n_level;
    t_dur   r_dur,    n_dur;

    t_dur       dur_inc;
    t_timer     phase_dec;
    t_timer     sample_dec;
    logic       level_now;
    logic       elapsed;
    t_hold_pick pick;

    // duration advances on every tick, blocked or not, and saturates
    assign dur_inc    = (r_dur != DUR_MAX) ? r_dur + DUR_W'(1) : r_dur;
    assign phase_dec  = (r_phase_cnt != '0)  ? r_phase_cnt - TIMER_W'(1)  : '0;
    assign sample_dec = (r_sample_cnt != '0) ? r_sample_cnt - TIMER_W'(1) : '0;
    // sample the pin when the sample countdown runs out
    assign level_now  = (sample_dec == '0) ? i_in_data.pin_level : r_level;
    assign elapsed    = (phase_dec == '0);

    bchd_hold_pick u_hold_pick (
        .i_dur        (dur_inc),
        .i_hold_count (r_hold_count),
        .i_thresh     (r_thresh),
        .o_pick       (pick)
    );

    // next state of the phase machine and its timers
    always_comb begin
        n_dur        = dur_inc;
        n_phase      = r_phase;
        n_phase_cnt  = r_phase_cnt;
        n_sample_cnt = r_sample_cnt;
        n_level      = r_level;
        if (!i_in_data.blocked) begin
            n_phase_cnt  = phase_dec;
            n_sample_cnt = (sample_dec == '0) ? r_sample_period : sample_dec;
            n_level      = level_now;
            case (r_phase)
                PH_DEBOUNCE: begin
                    if (elapsed) begin
                        if (level_now == LVL_PRESSED) begin
                            n_phase     = PH_PRESSED;
                            n_phase_cnt = r_debounce;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_PRESSED: begin
                    // release counts only once the countdown has run out
                    if (elapsed) begin
                        if (level_now == LVL_RELEASED) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase     = PH_WAIT_HOLD;
                            n_phase_cnt = r_hold_wait;
                        end
                    end
                end
                PH_WAIT_HOLD: begin
                    if (level_now == LVL_RELEASED) begin
                        n_phase = PH_IDLE;
                    end else if (elapsed) begin
                        n_phase = PH_HOLD;
                    end
                end
                PH_HOLD: begin
                    if (level_now == LVL_RELEASED) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    // idle, and any stray code behaves as idle
                    n_phase = PH_IDLE;
                    if (level_now == LVL_PRESSED) begin
                        n_dur       = '0;
                        n_phase     = PH_DEBOUNCE;
                        n_phase_cnt = r_debounce;
                    end
                end
            endcase
        end
    end

    // result of this tick
    always_comb begin
        result = '{event_res: EV_NONE, hold_index: 2'd0};
        if (!i_in_data.blocked) begin
            case (r_phase)
                PH_PRESSED: begin
                    if (elapsed && (level_now == LVL_RELEASED)) begin
                        result.event_res = EV_CLICK;
                    end
                end
                PH_WAIT_HOLD: begin
                    if (level_now == LVL_RELEASED) begin
                        result.event_res = EV_CLICK;
                    end
                end
                PH_HOLD: begin
                    if ((level_now == LVL_RELEASED) && pick.found) begin
                        result.event_res  = EV_HOLD;
                        result.hold_index = pick.index;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_phase_cnt  <= '0;
            r_sample_cnt <= '0;
            r_level      <= LVL_RELEASED;
            r_dur        <= '0;
        end else if (in_acc) begin
            r_phase      <= n_phase;
            r_phase_cnt  <= n_phase_cnt;
            r_sample_cnt <= n_sample_cnt;
            r_level      <= n_level;
            r_dur        <= n_dur;
        end
    end

    // ---------------------------------------------------------------
    // Output staging: refill the result register from skid first
    // ---------------------------------------------------------------
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = in_acc;
                n_out_data  = result;
            end
        end else if (in_acc) begin
            // result register stalled: park the new item
            n_skid_valid = 1'b1;
            n_skid_data  = result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while result register empty");

    a_blocked_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.blocked) |=>
            (r_phase == $past(r_phase)) && (r_phase_cnt == $past(r_phase_cnt)))
        else $error("blocked tick moved the phase machine");

    a_idle_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_phase == PH_IDLE)) |=> (r_phase == PH_IDLE || r_phase == PH_DEBOUNCE))
        else $error("idle left for a phase other than debounce");

    a_no_item_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_phase) && $stable(r_dur))
        else $error("state advanced without an accepted item");

    a_hold_event_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (result.event_res == EV_HOLD)) |-> (r_phase == PH_HOLD))
        else $error("hold event outside hold phase");

endmodule
`default_nettype wire

FILE: rtl/bchd_hold_pick.sv
`default_nettype none
module bchd_hold_pick import bchd_pkg::*; (
    input  var t_dur                  i_dur,
    input  var logic [HCOUNT_W-1:0]   i_hold_count,
    input  var t_dur [HOLD_SLOTS-1:0] i_thresh,
    output t_hold_pick                o_pick
);

    logic [HCOUNT_W-1:0] enabled;
    t_dur                best;

    // largest enabled threshold not above the duration, lowest index on ties
    always_comb begin
        enabled = (i_hold_count > HCOUNT_W'(HOLD_SLOTS)) ? HCOUNT_W'(HOLD_SLOTS)
                                                         : i_hold_count;
        best   = '0;
        o_pick = '0;
        for (int i = 0; i < HOLD_SLOTS; i++) begin
            if ((HCOUNT_W'(i) < enabled) && (i_thresh[i] <= i_dur)
                    && (!o_pick.found || (i_thresh[i] > best))) begin
                best         = i_thresh[i];
                o_pick.found = 1'b1;
                o_pick.index = 2'(i);
            end
        end
    end

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bchd_pkg::*;

    // Far above the slowest correct run: about 1.7k items, each held up by idling
    // and result stalls, plus the drains and the register writes between the tests.
    localparam int unsigned CYCLE_LIMIT = 200_000;

    // Block inputs, all known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_ready = 1'b1;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;

    // Block outputs
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Register copy, at the reset values of the block
    t_timer                cfg_period     = 16'd20;
    t_timer                cfg_debounce   = 16'd50;
    t_timer                cfg_hold_wait  = 16'd1000;
    logic [HCOUNT_W-1:0]   cfg_hold_count = '0;
    t_dur                  cfg_thresh [HOLD_SLOTS] = '{default: '0};

    // Button state copy
    t_phase                btn_phase   = PH_IDLE;
    t_timer                phase_left  = '0;
    t_timer                sample_left = '0;
    logic                  seen_level  = LVL_RELEASED;
    t_dur                  press_ticks = '0;

    // Expected event per accepted tick, oldest first
    t_out_item             pending_events [$];

    int unsigned           cycle_count = 0;
    int                    items_sent  = 0;
    int                    results_seen = 0;
    int                    fail_count  = 0;
    bit                    idle_en     = 1'b1;
    int                    stall_left  = 0;

    button_click_hold_detector u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Advance the button state by one tick and return the event it raises.
    // The press duration counts every tick, blocked or not; everything else
    // freezes on a blocked tick.
    function automatic t_out_item advance_button(input logic pin, input logic blk);
        t_out_item  r;
        logic       elapsed;
        logic       found;
        logic [1:0] pick_idx;
        t_dur       best;
        int         n_on;
        r = '{event_res: EV_NONE, hold_index: 2'd0};
        if (press_ticks != DUR_MAX) press_ticks = press_ticks + 1'b1;
        if (!blk) begin
            if (phase_left != '0) phase_left = phase_left - 1'b1;
            if (sample_left != '0) sample_left = sample_left - 1'b1;
            // Sample the pin only when the sample countdown has run out
            if (sample_left == '0) begin
                seen_level  = pin;
                sample_left = cfg_period;
            end
            elapsed = (phase_left == '0);
            case (btn_phase)
                PH_DEBOUNCE: begin
                    if (elapsed) begin
                        if (seen_level == LVL_PRESSED) begin
                            btn_phase  = PH_PRESSED;
                            phase_left = cfg_debounce;
                        end else begin
                            btn_phase = PH_IDLE;
                        end
                    end
                end
                PH_PRESSED: begin
                    // A release only counts once the wait has run out
                    if (elapsed) begin
                        if (seen_level == LVL_RELEASED) begin
                            r.event_res = EV_CLICK;
                            btn_phase   = PH_IDLE;
                        end else begin
                            phase_left = cfg_hold_wait;
                            btn_phase  = PH_WAIT_HOLD;
                        end
                    end
                end
                PH_WAIT_HOLD: begin
                    if (seen_level == LVL_RELEASED) begin
                        r.event_res = EV_CLICK;
                        btn_phase   = PH_IDLE;
                    end else if (elapsed) begin
                        btn_phase = PH_HOLD;
                    end
                end
                PH_HOLD: begin
                    if (seen_level == LVL_RELEASED) begin
                        // Pick the largest enabled threshold not above the
                        // duration; ties keep the lowest index
                        n_on     = (cfg_hold_count > HOLD_SLOTS) ? HOLD_SLOTS
                                                                 : int'(cfg_hold_count);
                        found    = 1'b0;
                        best     = '0;
                        pick_idx = 2'd0;
                        for (int i = 0; i < n_on; i++) begin
                            if (cfg_thresh[i] <= press_ticks &&
                                    (!found || cfg_thresh[i] > best)) begin
                                best     = cfg_thresh[i];
                                pick_idx = 2'(i);
                                found    = 1'b1;
                            end
                        end
                        if (found) begin
                            r.event_res  = EV_HOLD;
                            r.hold_index = pick_idx;
                        end
                        btn_phase = PH_IDLE;
                    end
                end
                default: begin
                    btn_phase = PH_IDLE;
                    if (seen_level == LVL_PRESSED) begin
                        press_ticks = '0;
                        btn_phase   = PH_DEBOUNCE;
                        phase_left  = cfg_debounce;
                    end
                end
            endcase
        end
        return r;
    endfunction

    // Predict on every accepted item, check every accepted result. Both use
    // the values from just before the edge, since all drives are nonblocking.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                pending_events.push_back(advance_button(i_in_data.pin_level,
                                                        i_in_data.blocked));
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (pending_events.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("tb_top: result %0d with nothing expected: event %0d index %0d",
                                 results_seen, o_out_data.event_res, o_out_data.hold_index);
                end else begin
                    want = pending_events.pop_front();
                    if (o_out_data.event_res !== want.event_res ||
                            o_out_data.hold_index !== want.hold_index) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("tb_top: result %0d expected event %0d index %0d, got event %0d index %0d",
                                     results_seen, want.event_res, want.hold_index,
                                     o_out_data.event_res, o_out_data.hold_index);
                    end
                end
            end
        end
    end

    // Result side: stall in random bursts while idling is on
    always @(posedge i_clk) begin
        if (!idle_en) begin
            i_out_ready <= 1'b1;
            stall_left  <= 0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left  <= 0;
            i_out_ready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(1, 6);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Send one tick item; hold valid and payload until it is taken
    task automatic send_tick(input logic pin, input logic blk);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{pin_level: pin, blocked: blk};
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Drop valid and wait until every expected event has arrived, then give
    // the result register and skid stage time to settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_events.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SAMPLE_PERIOD: cfg_period     = val[TIMER_W-1:0];
            REG_DEBOUNCE:      cfg_debounce   = val[TIMER_W-1:0];
            REG_HOLD_WAIT:     cfg_hold_wait  = val[TIMER_W-1:0];
            REG_HOLD_COUNT:    cfg_hold_count = val[HCOUNT_W-1:0];
            default:           cfg_thresh[idx - REG_THRESH_0] = val[DUR_W-1:0];
        endcase
    endtask

    task automatic set_timing(input int period, input int debounce, input int hold_wait);
        drain_results();
        cfg_write(REG_SAMPLE_PERIOD, period);
        cfg_write(REG_DEBOUNCE, debounce);
        cfg_write(REG_HOLD_WAIT, hold_wait);
    endtask

    task automatic set_holds(input int count, input int t0, input int t1,
                             input int t2, input int t3);
        drain_results();
        cfg_write(REG_HOLD_COUNT, count);
        cfg_write(REG_THRESH_0, t0);
        cfg_write(REG_THRESH_1, t1);
        cfg_write(REG_THRESH_2, t2);
        cfg_write(REG_THRESH_3, t3);
    endtask

    // One press and release; bounce_pct flips the pin, blk_pct blocks ticks
    task automatic run_press(input int press_n, input int release_n,
                             input int blk_pct, input int bounce_pct);
        for (int k = 0; k < press_n; k++)
            send_tick(($urandom_range(0, 99) < bounce_pct) ? LVL_RELEASED : LVL_PRESSED,
                      $urandom_range(0, 99) < blk_pct);
        for (int k = 0; k < release_n; k++)
            send_tick(($urandom_range(0, 99) < bounce_pct) ? LVL_PRESSED : LVL_RELEASED,
                      $urandom_range(0, 99) < blk_pct);
    endtask

    // A few ticks on the reset registers; the first tick samples the pin
    task automatic test_reset_defaults();
        send_tick(LVL_RELEASED, 1'b0);
        send_tick(LVL_PRESSED, 1'b1);
        send_tick(LVL_RELEASED, 1'b0);
    endtask

    // Clicks: released inside the pressed wait (no early click) and released
    // during the hold wait. A zero sample period samples every tick.
    task automatic test_click();
        set_timing(0, 2, 4);
        set_holds(4, 3, 8, 8, 24'hFF_FFFF);
        // let the old sample countdown run out
        run_press(0, 24, 0, 0);
        run_press(3, 3, 0, 0);
        run_press(6, 3, 0, 0);
    endtask

    // Hold release: equal largest thresholds give the lowest index, and a
    // hold count above the slot number enables every slot
    task automatic test_hold_pick();
        run_press(12, 2, 0, 0);
        set_holds(7, 0, 1, 2, 3);
        run_press(12, 2, 0, 0);
    endtask

    // Hold release with no threshold met, and with none enabled
    task automatic test_no_threshold();
        set_holds(1, 24'hFF_FFFF, 0, 0, 0);
        run_press(12, 2, 0, 0);
        set_holds(0, 0, 0, 0, 0);
        run_press(12, 2, 0, 0);
    endtask

    // Blocked ticks freeze the machine but still count toward the duration
    task automatic test_blocked_ticks();
        set_holds(4, 5, 10, 15, 20);
        for (int k = 0; k < 20; k++) send_tick(LVL_PRESSED, (k % 3) == 1);
        send_tick(LVL_RELEASED, 1'b1);
        send_tick(LVL_RELEASED, 1'b1);
        run_press(0, 3, 0, 0);
    endtask

    // Zero debounce and hold wait elapse on the next tick
    task automatic test_zero_registers();
        set_timing(0, 0, 0);
        set_holds(2, 0, 5, 0, 0);
        run_press(8, 2, 0, 0);
        run_press(1, 2, 0, 0);
    endtask

    // Full-scale hold wait: a release well inside it still gives a click,
    // with and without blocked ticks along the way
    task automatic test_timer_extremes();
        set_timing(1, 2, 16'hFFFF);
        run_press(12, 3, 0, 0);
        run_press(30, 3, 10, 0);
    endtask

    // Random register setting, then mostly well-formed presses with random
    // lengths, bounce and blocked ticks, mixed with raw noise
    task automatic run_random_phase(input int n_items, input bit with_gaps);
        int stop_at;
        int th [HOLD_SLOTS];
        stop_at = items_sent + n_items;
        for (int i = 0; i < HOLD_SLOTS; i++) begin
            if ($urandom_range(0, 9) == 0)
                th[i] = $urandom() & 32'h00FF_FFFF;
            else if (i > 0 && $urandom_range(0, 5) == 0)
                th[i] = th[i-1];
            else
                th[i] = $urandom_range(0, 70);
        end
        set_timing($urandom_range(0, 3), $urandom_range(0, 6), $urandom_range(0, 15));
        set_holds($urandom_range(0, 7), th[0], th[1], th[2], th[3]);
        idle_en = with_gaps;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 10))
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                run_press($urandom_range(1, 60), $urandom_range(1, 20), 8, 5);
            end
            // now and then hold off until the block has caught up
            if ($urandom_range(0, 39) == 0) drain_results();
        end
    endtask

    // Last phase runs without any idling
    task automatic test_random_presses();
        repeat (4) run_random_phase(320, 1'b1);
        run_random_phase(180, 1'b0);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_click();
        test_hold_pick();
        test_no_threshold();
        test_blocked_ticks();
        test_zero_registers();
        test_timer_extremes();
        test_random_presses();
        drain_results();
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
